@@ src/adc_noise_random_byte_mixer_assert.svh @@
// Assertion macros for the ADC-noise random byte mixer.
// Depends on nothing; included by the top level.
`ifndef ADC_NOISE_RANDOM_BYTE_MIXER_ASSERT_SVH
`define ADC_NOISE_RANDOM_BYTE_MIXER_ASSERT_SVH

// Clocked check, off while reset is held
`define ANRBM_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ANRBM_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/anrbm_pkg.sv @@
// Package for the ADC-noise random byte mixer: widths, phase codes,
// rotate and mixing-stack push functions. No dependencies.
package anrbm_pkg;

    localparam int SAMPLE_W = 10;
    localparam int BYTE_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int PAIR_W   = 2;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [PAIR_W-1:0]  pair_t;

    localparam phase_t PHASE_FIRST = 3'd0;
    localparam phase_t PHASE_LAST  = 3'd7;
    localparam phase_t ROT_BASE    = 3'd7;

    // Rotate left by a 0..7 amount
    function automatic byte_t rotl8(input byte_t v, input phase_t r);
        logic [2*BYTE_W-1:0] wide;
        wide = {v, v} << r;
        return wide[2*BYTE_W-1:BYTE_W];
    endfunction

    // Push each differing bit of the pair into the left stack, bit 0 first
    function automatic byte_t push_left(input byte_t stk, input byte_t lb, input byte_t rb);
        byte_t s;
        s = stk;
        for (int j = 0; j < BYTE_W; j++) begin
            if (lb[j] != rb[j]) begin
                s = (s << 1) ^ s ^ byte_t'(lb[j]);
            end
        end
        return s;
    endfunction

    // Same for the right stack, pushing in at the top bit
    function automatic byte_t push_right(input byte_t stk, input byte_t lb, input byte_t rb);
        byte_t s;
        s = stk;
        for (int j = 0; j < BYTE_W; j++) begin
            if (lb[j] != rb[j]) begin
                s = (s >> 1) ^ s ^ {lb[j], {(BYTE_W-1){1'b0}}};
            end
        end
        return s;
    endfunction

endpackage

@@ src/adc_noise_random_byte_mixer.sv @@
// Top level of the ADC-noise random byte mixer: pairing, mixing stacks,
// xorshift output register. Depends on anrbm_pkg and the assertion header.
//
//  channel | ports                             | moves
//  --------+-----------------------------------+------------------------------
//  input   | s_valid, s_ready, s_sample[9:0]   | one converter sample per item
//  result  | m_valid, m_ready, m_random_byte   | one mixed byte per 8 samples
//
// One sample is taken per cycle unless stalled; its update (hold a left sample, or rotate
// XOR and eight-step stack push, plus xorshift on the eighth) settles combinationally into the state registers.
// Every eighth sample loads the result register; that byte shows in the next cycle.
// A held result stalls only the eighth sample of the next byte; the others
// keep flowing. Synchronous active-low reset clears all state but the result byte, and the phase.
`include "adc_noise_random_byte_mixer_assert.svh"

module adc_noise_random_byte_mixer
    import anrbm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_W-1:0]   m_random_byte
);

    byte_t  left_stack_reg,  left_stack_next;
    byte_t  right_stack_reg, right_stack_next;
    byte_t  prev_out_reg,    prev_out_next;
    byte_t  rot_acc_reg,     rot_acc_next;
    logic   choice_reg,      choice_next;
    byte_t  held_left_reg,   held_left_next;
    phase_t phase_reg,       phase_next;
    logic   m_valid_reg,     m_valid_next;
    byte_t  m_byte_reg,      m_byte_next;

    logic  s_accept;
    logic  emit;
    byte_t smp;
    pair_t pair;
    byte_t xs;

    assign smp  = s_sample[BYTE_W-1:0];
    assign pair = phase_reg[PHASE_W-1:1];

    // Only the byte-closing sample needs the result register free
    assign s_ready  = !m_valid_reg || m_ready || (phase_reg != PHASE_LAST);
    assign s_accept = s_valid && s_ready;
    assign emit     = s_accept && (phase_reg == PHASE_LAST);

    always_comb begin
        left_stack_next  = left_stack_reg;
        right_stack_next = right_stack_reg;
        prev_out_next    = prev_out_reg;
        rot_acc_next     = rot_acc_reg;
        choice_next      = choice_reg;
        held_left_next   = held_left_reg;
        phase_next       = phase_reg;
        m_byte_next      = m_byte_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        xs               = prev_out_reg ^ (prev_out_reg >> 3) ^ (prev_out_reg << 5)
                           ^ (prev_out_reg >> 4);

        if (s_accept) begin
            phase_next = phase_reg + 1'b1;
            if (!phase_reg[0]) begin
                // left sample: hold it, open a new byte on the first one
                held_left_next = smp;
                if (phase_reg == PHASE_FIRST) begin
                    rot_acc_next = '0;
                    choice_next  = left_stack_reg[0] ^ right_stack_reg[0];
                end
            end else begin
                rot_acc_next = rot_acc_reg
                               ^ rotl8(held_left_reg, phase_t'(pair))
                               ^ rotl8(smp, ROT_BASE - phase_t'(pair));
                if (!choice_reg) begin
                    left_stack_next = push_left(left_stack_reg, held_left_reg, smp);
                end else begin
                    right_stack_next = push_right(right_stack_reg, held_left_reg, smp);
                end
                if (phase_reg == PHASE_LAST) begin
                    prev_out_next = xs ^ rot_acc_next;
                    m_byte_next   = prev_out_next ^ left_stack_next ^ right_stack_next;
                    m_valid_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_stack_reg  <= '0;
            right_stack_reg <= '0;
            prev_out_reg    <= '0;
            rot_acc_reg     <= '0;
            choice_reg      <= 1'b0;
            held_left_reg   <= '0;
            phase_reg       <= PHASE_FIRST;
            m_valid_reg     <= 1'b0;
        end else begin
            left_stack_reg  <= left_stack_next;
            right_stack_reg <= right_stack_next;
            prev_out_reg    <= prev_out_next;
            rot_acc_reg     <= rot_acc_next;
            choice_reg      <= choice_next;
            held_left_reg   <= held_left_next;
            phase_reg       <= phase_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_random_byte = m_byte_reg;

    `ANRBM_ASSERT_RST(a_rise_after_last, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(emit), "result appeared without a byte-closing item")

    `ANRBM_ASSERT_RST(a_phase_step, aclk, aresetn,
        s_accept |=> phase_reg == phase_t'($past(phase_reg) + 1'b1), "phase did not advance")

    `ANRBM_ASSERT_RST(a_no_overwrite, aclk, aresetn,
        (m_valid_reg && !m_ready && phase_reg == PHASE_LAST) |-> !s_ready,
        "held result could be overwritten")

    `ANRBM_ASSERT(a_reset_clears, aclk,
        !aresetn |=> !m_valid_reg && phase_reg == PHASE_FIRST, "reset left state behind")

endmodule
